// ===== hdl/hsm_pkg.sv =====
// Shared constants, command type and table functions for the windowed STFT magnitude block.
package hsm_pkg;

    localparam int NFFT_DEF        = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int RING_DEPTH      = 64;
    localparam int RING_AW         = 6;
    localparam int IDX_W           = 6;
    localparam int STG_W           = 3;
    localparam int HOP_W           = 7;
    localparam int MAG_W           = 16;
    localparam int BIN_W           = 6;
    localparam int FRAME_W         = 16;
    localparam int IN_DATA_W       = 16;
    localparam int OUT_DATA_W      = 40;
    localparam logic [HOP_W-1:0] HOP_RESET = 7'd16;

    localparam logic signed [63:0] HAMMING_A_Q15 = 64'sd17695;
    localparam logic signed [63:0] HAMMING_B_Q15 = 64'sd15073;
    localparam logic [63:0]        HALF_PI_Q30   = 64'd1686629713;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic               ring_we;
        logic [RING_AW-1:0] ring_wp;
        logic               load_rd;
        logic               bf_rd;
        logic               bf_mul;
        logic               bf_wa;
        logic               bf_wb;
        logic               mag_rd;
        logic               mag_sq;
        logic               mag_init;
        logic               root_step;
        logic [IDX_W-1:0]   idx;
        logic [STG_W-1:0]   stage;
    } dp_cmd_t;

    // Number of digit steps of the square root unit (half the radicand width).
    function automatic int root_steps(input int sb);
        return (sb + 2) + ((sb <= 17) ? (17 - sb) : 0);
    endfunction

    function automatic logic [63:0] taylor_div(input logic [63:0] q, input int k,
                                               input logic odd);
        logic [63:0] r;
        r = q;
        if (odd) begin
            case (k)
                1: r = q / 6;
                2: r = q / 20;
                3: r = q / 42;
                4: r = q / 72;
                5: r = q / 110;
                6: r = q / 156;
                default: r = q / 210;
            endcase
        end else begin
            case (k)
                1: r = q / 2;
                2: r = q / 12;
                3: r = q / 30;
                4: r = q / 56;
                5: r = q / 90;
                6: r = q / 132;
                default: r = q / 182;
            endcase
        end
        return r;
    endfunction

    function automatic logic signed [63:0] taylor_q30(input logic [63:0] t_in,
                                                      input logic [63:0] x2,
                                                      input logic odd);
        logic [63:0]        t;
        logic signed [63:0] sum;
        int                 k;
        t   = t_in;
        sum = $signed(t_in);
        for (k = 1; k <= 7; k++) begin
            t = taylor_div((t * x2) >> 30, k, odd);
            if ((k & 1) == 1)
                sum = sum - $signed(t);
            else
                sum = sum + $signed(t);
        end
        return sum;
    endfunction

    // Cosine of a phase given as a fraction of a full turn, Q15, saturated.
    function automatic logic signed [15:0] cos_q15(input logic [31:0] p);
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic signed [63:0] v;
        logic [63:0]        mag;
        r  = {34'd0, p[29:0]};
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        case (p[31:30])
            2'd0:    v =  taylor_q30(64'd1 << 30, x2, 1'b0);
            2'd1:    v = -taylor_q30(x, x2, 1'b1);
            2'd2:    v = -taylor_q30(64'd1 << 30, x2, 1'b0);
            default: v =  taylor_q30(x, x2, 1'b1);
        endcase
        mag = ((v < 0) ? 64'(-v) : 64'(v)) + 64'd16384;
        mag = mag >> 15;
        if (v < 0)
            return (mag > 64'd32768) ? -16'sd32768 : 16'(-mag);
        return (mag > 64'd32767) ? 16'sd32767 : 16'(mag);
    endfunction

    function automatic logic [15:0] win_q15(input logic [31:0] p);
        logic signed [63:0] c;
        logic signed [63:0] w;
        c = 64'(cos_q15(p));
        w = HAMMING_A_Q15 - (((HAMMING_B_Q15 * (c + 64'sd32768) + 64'sd16384) >>> 15)
            - HAMMING_B_Q15);
        return (w > 64'sd32767) ? 16'd32767 : 16'(w);
    endfunction

    function automatic logic signed [16:0] tw_re_q15(input logic [31:0] p);
        return 17'(cos_q15(p));
    endfunction

    function automatic logic signed [16:0] tw_im_q15(input logic [31:0] p);
        logic signed [16:0] c;
        c = 17'(cos_q15(p - 32'h4000_0000));
        return -c;
    endfunction

endpackage

// ===== hdl/hsm_ctrl.sv =====
// Sequencer for the STFT block: record and hop tracking, frame phases and the output register.
module hsm_ctrl
    import hsm_pkg::*;
#(
    parameter int NFFT_POINTS = NFFT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_restart,
    input  logic               cfg_we,
    input  logic [HOP_W-1:0]   cfg_wdata,
    input  logic [MAG_W-1:0]   dp_mag,
    output dp_cmd_t            cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [MAG_W-1:0]   out_mag,
    output logic [BIN_W-1:0]   out_bin,
    output logic [FRAME_W-1:0] out_frame,
    output logic               out_last
);

    localparam int LOG2N      = $clog2(NFFT_POINTS);
    localparam int CNT_W      = LOG2N + 1;
    localparam int ROOT_STEPS = root_steps(SAMPLE_BITS);
    localparam int RC_W       = $clog2(ROOT_STEPS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LOAD     = 4'd1;
    localparam logic [3:0] S_BF_RD    = 4'd2;
    localparam logic [3:0] S_BF_MUL   = 4'd3;
    localparam logic [3:0] S_BF_WA    = 4'd4;
    localparam logic [3:0] S_BF_WB    = 4'd5;
    localparam logic [3:0] S_MAG_RD   = 4'd6;
    localparam logic [3:0] S_MAG_SQ   = 4'd7;
    localparam logic [3:0] S_MAG_INIT = 4'd8;
    localparam logic [3:0] S_ROOT     = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    localparam logic [CNT_W-1:0] N_C      = CNT_W'(NFFT_POINTS);
    localparam logic [CNT_W-1:0] LOAD_END = CNT_W'(NFFT_POINTS + 1);
    localparam logic [CNT_W-1:0] BF_END   = CNT_W'(NFFT_POINTS / 2 - 1);
    localparam logic [CNT_W-1:0] BIN_END  = CNT_W'(NFFT_POINTS / 2);
    localparam logic [STG_W-1:0] STG_END  = STG_W'(LOG2N - 1);
    localparam logic [RC_W-1:0]  ROOT_END = RC_W'(ROOT_STEPS - 1);

    logic [3:0]         state_reg, state_next;
    logic [HOP_W-1:0]   hop_size_reg;
    logic [RING_AW-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [HOP_W-1:0]   hop_reg, hop_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [STG_W-1:0]   stage_reg, stage_next;
    logic [RC_W-1:0]    root_cnt_reg, root_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [MAG_W-1:0]   out_mag_reg;
    logic [BIN_W-1:0]   out_bin_reg;
    logic [FRAME_W-1:0] out_frame_reg;
    logic               out_last_reg;

    logic               accept;
    logic               out_load;
    logic [CNT_W-1:0]   fill_eff;
    logic [HOP_W-1:0]   hop_eff;
    logic [HOP_W-1:0]   hop_inc;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign fill_eff = in_restart ? '0 : fill_reg;
    assign hop_eff  = in_restart ? '0 : hop_reg;
    assign hop_inc  = hop_eff + HOP_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        hop_next      = hop_reg;
        frame_next    = frame_reg;
        cnt_next      = cnt_reg;
        stage_next    = stage_reg;
        root_cnt_next = root_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    wp_next    = wp_reg + RING_AW'(1);
                    frame_next = in_restart ? '0 : frame_reg;
                    cnt_next   = '0;
                    if (fill_eff < N_C)
                    begin
                        fill_next = fill_eff + CNT_W'(1);
                        hop_next  = hop_eff;
                        if (fill_eff + CNT_W'(1) == N_C)
                        begin
                            hop_next   = '0;
                            state_next = S_LOAD;
                        end
                    end
                    else
                    begin
                        fill_next = fill_eff;
                        if (hop_inc >= hop_size_reg)
                        begin
                            hop_next   = '0;
                            state_next = S_LOAD;
                        end
                        else
                        begin
                            hop_next = hop_inc;
                        end
                    end
                end
            end
            S_LOAD:
            begin
                if (cnt_reg == LOAD_END)
                begin
                    cnt_next   = '0;
                    stage_next = '0;
                    state_next = S_BF_RD;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_BF_RD:  state_next = S_BF_MUL;
            S_BF_MUL: state_next = S_BF_WA;
            S_BF_WA:  state_next = S_BF_WB;
            S_BF_WB:
            begin
                state_next = S_BF_RD;
                if (cnt_reg == BF_END)
                begin
                    cnt_next = '0;
                    if (stage_reg == STG_END)
                        state_next = S_MAG_RD;
                    else
                        stage_next = stage_reg + STG_W'(1);
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_MAG_RD: state_next = S_MAG_SQ;
            S_MAG_SQ: state_next = S_MAG_INIT;
            S_MAG_INIT:
            begin
                root_cnt_next = '0;
                state_next    = S_ROOT;
            end
            S_ROOT:
            begin
                root_cnt_next = root_cnt_reg + RC_W'(1);
                if (root_cnt_reg == ROOT_END)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    if (cnt_reg == BIN_END)
                    begin
                        frame_next = frame_reg + FRAME_W'(1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = S_MAG_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hop_size_reg  <= HOP_RESET;
            wp_reg        <= '0;
            fill_reg      <= '0;
            hop_reg       <= '0;
            frame_reg     <= '0;
            cnt_reg       <= '0;
            stage_reg     <= '0;
            root_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            hop_reg       <= hop_next;
            frame_reg     <= frame_next;
            cnt_reg       <= cnt_next;
            stage_reg     <= stage_next;
            root_cnt_reg  <= root_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                hop_size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_mag_reg   <= dp_mag;
            out_bin_reg   <= BIN_W'(cnt_reg);
            out_frame_reg <= frame_reg;
            out_last_reg  <= (cnt_reg == BIN_END);
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.ring_we   = accept;
        cmd.ring_wp   = wp_reg;
        cmd.idx       = IDX_W'(cnt_reg);
        cmd.stage     = stage_reg;
        cmd.load_rd   = (state_reg == S_LOAD) && (cnt_reg < N_C);
        cmd.bf_rd     = (state_reg == S_BF_RD);
        cmd.bf_mul    = (state_reg == S_BF_MUL);
        cmd.bf_wa     = (state_reg == S_BF_WA);
        cmd.bf_wb     = (state_reg == S_BF_WB);
        cmd.mag_rd    = (state_reg == S_MAG_RD);
        cmd.mag_sq    = (state_reg == S_MAG_SQ);
        cmd.mag_init  = (state_reg == S_MAG_INIT);
        cmd.root_step = (state_reg == S_ROOT);
    end

    assign out_valid = out_valid_reg;
    assign out_mag   = out_mag_reg;
    assign out_bin   = out_bin_reg;
    assign out_frame = out_frame_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hdl/hsm_dpath.sv =====
// Datapath of the STFT block: sample ring, windowing, butterfly unit and square root unit.
module hsm_dpath
    import hsm_pkg::*;
#(
    parameter int NFFT_POINTS = NFFT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    input  logic [IN_DATA_W-1:0] sample_in,
    output logic [MAG_W-1:0]     mag
);

    localparam int LOG2N = $clog2(NFFT_POINTS);
    localparam int SB    = SAMPLE_BITS;
    localparam int DW    = SB + 2;
    localparam int SHL   = (SB <= 17) ? 2 * (17 - SB) : 0;
    localparam int RSH   = (SB > 17) ? SB - 17 : 0;
    localparam int PW    = 2 * root_steps(SB);

    // Constant tables: window over the frame, twiddles over half a turn.
    logic [15:0]        win_tab [NFFT_POINTS];
    logic signed [16:0] twr_tab [NFFT_POINTS/2];
    logic signed [16:0] twi_tab [NFFT_POINTS/2];

    for (genvar gi = 0; gi < NFFT_POINTS; gi++)
    begin : g_win
        localparam logic [63:0] WPH = (64'(gi) << 32) / 64'(NFFT_POINTS - 1);
        assign win_tab[gi] = win_q15(WPH[31:0]);
    end

    for (genvar gi = 0; gi < NFFT_POINTS / 2; gi++)
    begin : g_tw
        localparam logic [31:0] TPH = 32'(64'(gi) << (32 - LOG2N));
        assign twr_tab[gi] = tw_re_q15(TPH);
        assign twi_tab[gi] = tw_im_q15(TPH);
    end

    // Sample as it enters the ring.
    logic signed [SB-1:0] samp;
    if (SB <= IN_DATA_W)
    begin : g_narrow
        assign samp = sample_in[SB-1:0];
    end
    else
    begin : g_wide
        assign samp = {{(SB - IN_DATA_W){1'b0}}, sample_in};
    end

    logic signed [SB-1:0] ring_mem [RING_DEPTH];
    logic signed [SB-1:0] ring_q_reg;
    logic [RING_AW-1:0]   ring_rd_addr;

    assign ring_rd_addr = cmd.ring_wp - RING_AW'(NFFT_POINTS) + RING_AW'(cmd.idx);

    always_ff @(posedge clk)
    begin
        if (cmd.ring_we)
            ring_mem[cmd.ring_wp] <= samp;
        ring_q_reg <= ring_mem[ring_rd_addr];
    end

    // Window load pipeline: ring read, multiply, round and store bit-reversed.
    logic                 ld_v1_reg, ld_v2_reg;
    logic [LOG2N-1:0]     ld_i1_reg, ld_i2_reg;
    logic signed [SB+16:0] prod_reg;
    logic signed [SB+17:0] ld_sum;
    logic signed [DW-1:0]  ld_val;
    logic [LOG2N-1:0]      ld_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_v1_reg <= 1'b0;
            ld_v2_reg <= 1'b0;
        end
        else
        begin
            ld_v1_reg <= cmd.load_rd;
            ld_v2_reg <= ld_v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_i1_reg <= LOG2N'(cmd.idx);
        ld_i2_reg <= ld_i1_reg;
        prod_reg  <= ring_q_reg * $signed({1'b0, win_tab[ld_i1_reg]});
    end

    assign ld_sum = (SB+18)'(prod_reg) + (SB+18)'(16384);
    assign ld_val = ld_sum[SB+16:15];

    always_comb
    begin
        for (int b = 0; b < LOG2N; b++)
            ld_addr[b] = ld_i2_reg[LOG2N-1-b];
    end

    // Butterfly addressing.
    logic [LOG2N-2:0] bf_j;
    logic [LOG2N-1:0] half_m, bf_k, bf_a, bf_b;
    logic [LOG2N-2:0] tw_idx;

    assign bf_j   = cmd.idx[LOG2N-2:0];
    assign half_m = LOG2N'(1) << cmd.stage;
    assign bf_k   = {1'b0, bf_j} & (half_m - LOG2N'(1));
    assign bf_a   = ((({1'b0, bf_j}) >> cmd.stage) << (cmd.stage + 1)) | bf_k;
    assign bf_b   = bf_a | half_m;
    assign tw_idx = (LOG2N-1)'(bf_k << (LOG2N - 1 - int'(cmd.stage)));

    // Working memory of the transform.
    logic signed [DW-1:0] re_mem [NFFT_POINTS];
    logic signed [DW-1:0] im_mem [NFFT_POINTS];
    logic signed [DW-1:0] rda_re_reg, rda_im_reg, rdb_re_reg, rdb_im_reg;
    logic [LOG2N-1:0]     rda_addr;
    logic                 wr_en;
    logic [LOG2N-1:0]     wr_addr;
    logic signed [DW-1:0] wr_re, wr_im;

    assign rda_addr = cmd.bf_rd ? bf_a : LOG2N'(cmd.idx);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            re_mem[wr_addr] <= wr_re;
            im_mem[wr_addr] <= wr_im;
        end
        if (cmd.bf_rd || cmd.mag_rd)
        begin
            rda_re_reg <= re_mem[rda_addr];
            rda_im_reg <= im_mem[rda_addr];
        end
        if (cmd.bf_rd)
        begin
            rdb_re_reg <= re_mem[bf_b];
            rdb_im_reg <= im_mem[bf_b];
        end
    end

    // Butterfly arithmetic.
    logic signed [DW+16:0] pr_rr_reg, pr_ii_reg, pr_ri_reg, pr_ir_reg;
    logic signed [DW+17:0] tr_sum, ti_sum;
    logic signed [DW+2:0]  tr, ti;
    logic signed [DW+3:0]  sa_re, sa_im, sb_re, sb_im;
    logic signed [DW-1:0]  na_re, na_im;
    logic signed [DW-1:0]  nb_re_reg, nb_im_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.bf_mul)
        begin
            pr_rr_reg <= rdb_re_reg * twr_tab[tw_idx];
            pr_ii_reg <= rdb_im_reg * twi_tab[tw_idx];
            pr_ri_reg <= rdb_re_reg * twi_tab[tw_idx];
            pr_ir_reg <= rdb_im_reg * twr_tab[tw_idx];
        end
        if (cmd.bf_wa)
        begin
            nb_re_reg <= sb_re[DW:1];
            nb_im_reg <= sb_im[DW:1];
        end
    end

    assign tr_sum = (DW+18)'(pr_rr_reg) - (DW+18)'(pr_ii_reg) + (DW+18)'(16384);
    assign ti_sum = (DW+18)'(pr_ri_reg) + (DW+18)'(pr_ir_reg) + (DW+18)'(16384);
    assign tr     = tr_sum[DW+17:15];
    assign ti     = ti_sum[DW+17:15];
    assign sa_re  = (DW+4)'(rda_re_reg) + (DW+4)'(tr) + (DW+4)'(1);
    assign sa_im  = (DW+4)'(rda_im_reg) + (DW+4)'(ti) + (DW+4)'(1);
    assign sb_re  = (DW+4)'(rda_re_reg) - (DW+4)'(tr) + (DW+4)'(1);
    assign sb_im  = (DW+4)'(rda_im_reg) - (DW+4)'(ti) + (DW+4)'(1);
    assign na_re  = sa_re[DW:1];
    assign na_im  = sa_im[DW:1];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ld_addr;
        wr_re   = ld_val;
        wr_im   = '0;
        if (ld_v2_reg)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.bf_wa)
        begin
            wr_en   = 1'b1;
            wr_addr = bf_a;
            wr_re   = na_re;
            wr_im   = na_im;
        end
        else if (cmd.bf_wb)
        begin
            wr_en   = 1'b1;
            wr_addr = bf_b;
            wr_re   = nb_re_reg;
            wr_im   = nb_im_reg;
        end
    end

    // Magnitude: squares, then a restoring square root, one digit a cycle.
    logic [2*DW-1:0] sq_re_reg, sq_im_reg;
    logic [2*DW-1:0] psum;
    logic [PW-1:0]   root_v_reg, root_res_reg, root_bit_reg;
    logic [PW-1:0]   trial;
    logic [PW-1:0]   root_m;

    assign psum  = sq_re_reg + sq_im_reg;
    assign trial = root_res_reg + root_bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mag_sq)
        begin
            sq_re_reg <= rda_re_reg * rda_re_reg;
            sq_im_reg <= rda_im_reg * rda_im_reg;
        end
        if (cmd.mag_init)
        begin
            root_v_reg   <= PW'(psum) << SHL;
            root_res_reg <= '0;
            root_bit_reg <= PW'(1) << (PW - 2);
        end
        else if (cmd.root_step)
        begin
            if (root_v_reg >= trial)
            begin
                root_v_reg   <= root_v_reg - trial;
                root_res_reg <= (root_res_reg >> 1) + root_bit_reg;
            end
            else
            begin
                root_res_reg <= root_res_reg >> 1;
            end
            root_bit_reg <= root_bit_reg >> 2;
        end
    end

    assign root_m = root_res_reg >> RSH;
    assign mag    = (root_m > PW'(65535)) ? 16'hFFFF : root_m[MAG_W-1:0];

endmodule

// ===== hdl/hamming_stft_magnitude.sv =====
// Top level of the Hamming-windowed short-time Fourier transform magnitude block.
// A sample that completes a frame starts the load phase, the butterfly phase (one shared
// butterfly that steps through a read, a multiply and two write states each) and then
// NFFT/2+1 bins, each read, squared and passed through the one-digit-a-cycle square root.
// rst_n clears all control state at once; the ring and working memories are not cleared.
module hamming_stft_magnitude
    import hsm_pkg::*;
#(
    parameter int NFFT_POINTS = NFFT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] sample
    input  logic                  s_axis_tuser,   // [0] restart
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] magnitude, [21:16] bin_index,
                                                  // [37:22] frame_index, [39:38] zero
    output logic                  m_axis_tlast,   // last_bin
    input  logic                  cfg_we,
    input  logic [HOP_W-1:0]      cfg_wdata       // hop_size
);

    // The sequencer owns the record bookkeeping (fill level, hop count and frame number),
    // steps the datapath through load, butterfly and magnitude phases, and holds the
    // output register. Input items are taken only while it is idle; the final bin of a
    // frame may still sit in the output register while the next item is accepted.
    dp_cmd_t            cmd;
    logic [MAG_W-1:0]   dp_mag;
    logic [MAG_W-1:0]   out_mag;
    logic [BIN_W-1:0]   out_bin;
    logic [FRAME_W-1:0] out_frame;

    hsm_ctrl #(
        .NFFT_POINTS (NFFT_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_restart (s_axis_tuser),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .dp_mag     (dp_mag),
        .cmd        (cmd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_mag    (out_mag),
        .out_bin    (out_bin),
        .out_frame  (out_frame),
        .out_last   (m_axis_tlast)
    );

    // The datapath keeps the newest samples in a ring, windows a frame into its working
    // memory in bit-reversed order, runs the radix-2 transform in place with a halving
    // butterfly, and takes the root of each bin's power.
    hsm_dpath #(
        .NFFT_POINTS (NFFT_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample_in (s_axis_tdata),
        .mag       (dp_mag)
    );

    assign m_axis_tdata = {2'b00, out_frame, out_bin, out_mag};

endmodule

// ===== hdl/hsm_checker.sv =====
// Port-level checker for the STFT magnitude block, bound to the top level.
module hsm_checker
    import hsm_pkg::*;
#(
    parameter int NFFT_POINTS = NFFT_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NFFT_POINTS / 2);

    a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[21:16] == LAST_BIN)
        else $error("last flag on a bin other than the final one");

    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[21:16] <= LAST_BIN)
        else $error("bin number beyond half the transform length");

    a_busy_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken while a frame is still being emitted");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result item changed");

endmodule

bind hamming_stft_magnitude hsm_checker #(
    .NFFT_POINTS (NFFT_POINTS)
) u_hsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== bench/hamming_stft_magnitude_test.sv =====
// Self-checking testbench for the Hamming-windowed STFT magnitude block.
module hamming_stft_magnitude_test
    import hsm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS       = 64;
    localparam int LOG_NPTS   = 6;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN   = 400;

    // One input item waiting for the driver.
    typedef struct {
        logic [15:0] sample;
        logic        restart;
    } sample_item_t;

    // One bin that the block is due to send.
    typedef struct {
        logic [MAG_W-1:0]   magnitude;
        logic [BIN_W-1:0]   bin_index;
        logic [FRAME_W-1:0] frame_index;
        logic               last_bin;
    } bin_result_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [15:0] sample
    logic                  s_axis_tuser;   // [0] restart
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [15:0] magnitude, [21:16] bin_index,
                                           // [37:22] frame_index, [39:38] zero
    logic                  m_axis_tlast;   // last_bin
    logic                  cfg_we;
    logic [HOP_W-1:0]      cfg_wdata;      // hop_size

    hamming_stft_magnitude u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // The clock runs with a 4 ns period.
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Queues shared between the stimulus, the driver and the monitor.
    sample_item_t pending_samples[$];
    bin_result_t  expected_bins[$];
    int           mismatches = 0;
    bit           burst_mode = 1'b0;   // when set, neither side draws random idle gaps
    int           hold_requests = 0;   // bumped by the stimulus to ask for a long stall

    // Predictor state: a mirror of the block's ring, counters and register.
    logic signed [15:0] pred_ring[RING_DEPTH];
    logic [5:0]         pred_wp;
    int unsigned        pred_fill;
    int unsigned        pred_hop_count;
    logic [15:0]        pred_frame;
    logic [HOP_W-1:0]   pred_hop_size;

    longint window_q15[NPTS];
    longint twiddle_re[NPTS];
    longint twiddle_im[NPTS];

    // Q30 Taylor series over a quarter wave; odd selects the sine series.
    function automatic longint series_q30(longint unsigned term, longint unsigned x_sq,
                                          bit odd);
        longint          acc;
        longint unsigned div;
        acc = longint'(term);
        for (int k = 1; k <= 7; k++)
        begin
            div  = odd ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
            term = ((term * x_sq) >> 30) / div;
            if (k % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        return acc;
    endfunction

    // Cosine of a 32-bit fraction of a full turn, rounded and saturated to Q15.
    function automatic longint cosine_q15(logic [31:0] phase);
        longint unsigned rem;
        longint unsigned x;
        longint unsigned x_sq;
        longint          v;
        longint          mag;
        rem  = {34'd0, phase[29:0]};
        x    = (rem * 64'd1686629713) >> 30;
        x_sq = (x * x) >> 30;
        case (phase[31:30])
            2'd0:    v =  series_q30(64'd1 << 30, x_sq, 1'b0);
            2'd1:    v = -series_q30(x, x_sq, 1'b1);
            2'd2:    v = -series_q30(64'd1 << 30, x_sq, 1'b0);
            default: v =  series_q30(x, x_sq, 1'b1);
        endcase
        mag = ((v < 0) ? -v : v) + 16384;
        mag = mag >> 15;
        if (v < 0)
            return (mag > 32768) ? -32768 : -mag;
        return (mag > 32767) ? 32767 : mag;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Windowing, scaled radix-2 transform and magnitudes for the newest full frame.
    task automatic transform_frame();
        longint      re[NPTS];
        longint      im[NPTS];
        longint      tr;
        longint      ti;
        longint      ar;
        longint      ai;
        longint      c;
        longint      s;
        int          rev;
        int          a;
        int          b;
        logic [5:0]  pos;
        bin_result_t r;
        longint unsigned pwr;
        longint unsigned m;
        for (int i = 0; i < NPTS; i++)
        begin
            pos = pred_wp - 6'(NPTS) + 6'(i);
            rev = 0;
            for (int bit_no = 0; bit_no < LOG_NPTS; bit_no++)
                rev |= ((i >> bit_no) & 1) << (LOG_NPTS - 1 - bit_no);
            re[rev] = (longint'(pred_ring[pos]) * window_q15[i] + 16384) >>> 15;
            im[rev] = 0;
        end
        for (int span = 2; span <= NPTS; span *= 2)
        begin
            for (int first = 0; first < NPTS; first += span)
            begin
                for (int k = 0; k < span / 2; k++)
                begin
                    a  = first + k;
                    b  = a + span / 2;
                    c  = twiddle_re[k * (NPTS / span)];
                    s  = twiddle_im[k * (NPTS / span)];
                    tr = (re[b] * c - im[b] * s + 16384) >>> 15;
                    ti = (re[b] * s + im[b] * c + 16384) >>> 15;
                    ar = re[a];
                    ai = im[a];
                    re[a] = (ar + tr + 1) >>> 1;
                    im[a] = (ai + ti + 1) >>> 1;
                    re[b] = (ar - tr + 1) >>> 1;
                    im[b] = (ai - ti + 1) >>> 1;
                end
            end
        end
        for (int k = 0; k <= NPTS / 2; k++)
        begin
            // Samples are Q1.15, so two extra bits bring the power to Q0.16 squared.
            pwr = longint'(re[k] * re[k] + im[k] * im[k]) << 2;
            m   = int_sqrt(pwr);
            r.magnitude   = (m > 65535) ? 16'hFFFF : 16'(m);
            r.bin_index   = 6'(k);
            r.frame_index = pred_frame;
            r.last_bin    = (k == NPTS / 2);
            expected_bins.push_back(r);
        end
        pred_frame++;
    endtask

    // Advance the predictor by one accepted sample.
    task automatic accept_sample(logic [15:0] sample, logic restart);
        if (restart)
        begin
            pred_fill      = 0;
            pred_hop_count = 0;
            pred_frame     = '0;
        end
        pred_ring[pred_wp] = sample;
        pred_wp++;
        if (pred_fill < NPTS)
        begin
            pred_fill++;
            if (pred_fill == NPTS)
            begin
                pred_hop_count = 0;
                transform_frame();
            end
        end
        else
        begin
            pred_hop_count = (pred_hop_count + 1) & 32'h7F;
            // A hop size of zero falls through here as a frame on every sample.
            if (pred_hop_count >= pred_hop_size)
            begin
                pred_hop_count = 0;
                transform_frame();
            end
        end
    endtask

    // Driver: one new item per handshake, with a drawn number of idle cycles in front.
    int          send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        logic         next_valid;
        sample_item_t item;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                accept_sample(s_axis_tdata, s_axis_tuser);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_samples.size() > 0)
                begin
                    item = pending_samples.pop_front();
                    s_axis_tdata <= item.sample;
                    s_axis_tuser <= item.restart;
                    next_valid   = 1'b1;
                    send_gap     = burst_mode ? 0 : $urandom_range(0, 5);
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // Monitor: checks each bin against the oldest expectation and paces tready.
    int recv_gap  = 0;
    int hold_left = 0;
    int holds_seen = 0;
    always @(posedge clk or negedge rst_n)
    begin
        bin_result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bins.size() == 0)
                begin
                    $error("unexpected bin item: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = expected_bins.pop_front();
                    if (m_axis_tdata[15:0] !== want.magnitude)
                    begin
                        $error("magnitude: expected %0d, got %0d", want.magnitude,
                               m_axis_tdata[15:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[21:16] !== want.bin_index)
                    begin
                        $error("bin_index: expected %0d, got %0d", want.bin_index,
                               m_axis_tdata[21:16]);
                        mismatches++;
                    end
                    if (m_axis_tdata[37:22] !== want.frame_index)
                    begin
                        $error("frame_index: expected %0d, got %0d", want.frame_index,
                               m_axis_tdata[37:22]);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.last_bin)
                    begin
                        $error("last_bin: expected %0d, got %0d", want.last_bin, m_axis_tlast);
                        mismatches++;
                    end
                end
                recv_gap = burst_mode ? 0 : $urandom_range(0, 5);
            end
            // A fresh stall request starts a long stretch with tready held low.
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: the run fails if no item moves on either side for too long.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Queue one sample for the driver.
    task automatic queue_sample(logic [15:0] sample, logic restart);
        sample_item_t item;
        item.sample  = sample;
        item.restart = restart;
        pending_samples.push_back(item);
    endtask

    // Random samples, with an occasional restart that throws away a partial frame.
    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            queue_sample(16'($urandom), ($urandom_range(0, 39) == 0));
    endtask

    // Wait until the sender is empty and every expected bin has come, then let it settle.
    task automatic drain();
        while (pending_samples.size() > 0 || s_axis_tvalid || expected_bins.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_hop(logic [HOP_W-1:0] hop);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= hop;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pred_hop_size = hop;
    endtask

    initial
    begin
        logic [31:0] phase;
        longint      c;
        longint      w;
        // Window and twiddle tables, built once from the Q15 cosine.
        for (int i = 0; i < NPTS; i++)
        begin
            phase = 32'((64'(i) << 32) / (NPTS - 1));
            c = cosine_q15(phase);
            w = 17695 - (((15073 * (c + 32768) + 16384) >> 15) - 15073);
            window_q15[i] = (w > 32767) ? 32767 : w;
            phase = 32'((64'(i) << 32) / NPTS);
            twiddle_re[i] = cosine_q15(phase);
            twiddle_im[i] = -cosine_q15(phase - 32'h4000_0000);
        end
        pred_wp        = '0;
        pred_fill      = 0;
        pred_hop_count = 0;
        pred_frame     = '0;
        pred_hop_size  = HOP_RESET;

        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset hop: a restart that discards a partial frame,
        // the sample extremes, then a record long enough for a first frame and one hop.
        @(negedge clk);
        queue_sample(16'h8000, 1'b1);
        queue_sample(16'h7FFF, 1'b0);
        queue_sample(16'h0000, 1'b1);
        for (int i = 0; i < 8; i++)
            queue_sample(i[0] ? 16'h7FFF : 16'h8000, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h0001, 1'b0);
        for (int i = 0; i < 77; i++)
            queue_sample(16'($urandom), 1'b0);
        drain();

        // Hop of one with no idling and a long receiver stall: the block must back up
        // its input while the sender keeps offering.
        write_hop(7'd1);
        burst_mode = 1'b1;
        hold_requests <= hold_requests + 1;
        @(negedge clk);
        queue_random(30);
        drain();
        burst_mode = 1'b0;

        // Hop of zero behaves as one.
        write_hop(7'd0);
        @(negedge clk);
        queue_random(10);
        drain();

        // The largest allowed hop and one equal to the frame length.
        write_hop(7'd64);
        @(negedge clk);
        queue_sample(16'h1234, 1'b1);
        queue_random(49);
        drain();

        write_hop(7'd127);
        @(negedge clk);
        queue_random(40);
        drain();

        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_bins.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
